FILE: sv/battery_charge_level_estimator_unit_defines.svh
// Assertion macros used by the battery charge level estimator checker.
`ifndef BATTERY_CHARGE_LEVEL_ESTIMATOR_UNIT_DEFINES_SVH
`define BATTERY_CHARGE_LEVEL_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define BCLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge.
`define BCLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bcle_pkg.sv
// Shared constants, types and register codes of the battery charge level estimator.
`timescale 1ns / 1ps
`default_nettype none
package bcle_pkg;

   localparam int ADC_BITS_DEF = 12;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [20:0] SUPPLY_NUM = 21'd1125300;
   localparam logic [15:0] SAT_MV     = 16'hFFFF;
   localparam logic [6:0]  PCT_MAX    = 7'd100;
   localparam logic [16:0] ALPHA_ONE  = 17'd65536;

   localparam logic        RST_SOURCE_MODE = 1'b0;
   localparam logic [23:0] RST_SCALE_Q16   = 24'd640000;
   localparam logic [16:0] RST_ALPHA_Q16   = 17'd32768;
   localparam logic [15:0] RST_MIN_MV      = 16'd3000;
   localparam logic [15:0] RST_MAX_MV      = 16'd4200;
   localparam logic [7:0]  RST_SAMPLE_CNT  = 8'd0;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Shared divider widths.
   localparam int DIV_N_W   = 40;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_MODE  = 3'd0,
      REG_SCALE_Q16    = 3'd1,
      REG_ALPHA_Q16    = 3'd2,
      REG_MIN_MV       = 3'd3,
      REG_MAX_MV       = 3'd4,
      REG_SAMPLE_COUNT = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic                      valid;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                      valid;
      logic signed [MUL_P_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: sv/bcle_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface bcle_req_if #(
   parameter int CODE_BITS = bcle_pkg::ADC_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
   modport mon    (input valid, input adc_code, input ready);
endinterface

interface bcle_rsp_if ();
   logic        valid;
   logic        ready;
   logic [6:0]  percent;
   logic [15:0] level_mv;

   modport source (output valid, output percent, output level_mv, input ready);
   modport sink   (input valid, input percent, input level_mv, output ready);
   modport mon    (input valid, input percent, input level_mv, input ready);
endinterface

interface bcle_csr_if ();
   logic                            valid;
   logic                            ready;
   logic [bcle_pkg::CSR_IDX_W-1:0]  index;
   logic [bcle_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
   modport mon    (input valid, input index, input wdata, input ready);
endinterface
`default_nettype wire

FILE: sv/battery_charge_level_estimator_unit.sv
// Top level of the battery charge level estimator: sequencer over a shared multiplier and divider.
//
// Usage: raw converter codes arrive as beats on req_ch. Each code becomes a millivolt sample,
// either code times scale_q16 (divider mode) or 1125300 / code (internal supply mode, a zero
// code reads as 65535 mV). The first sample of a burst seeds a Q16.16 moving average; later
// samples blend in with alpha_q16. After sample_count+1 samples one beat leaves on rsp_ch with
// the percent (clamped to 0..100, 0 when the limits are equal) and the filtered whole millivolts.
// Registers are written through csr_ch, which is always ready; write them only while idle.
// Flow: req_ch.ready is high only while the sequencer is idle. A sample that does not end a
// burst keeps it busy for a multiply in divider mode or a 40-step divide in supply mode
// (skipped for a zero code). A burst-ending sample adds the percent step (a multiply and a
// 40-step divide, both skipped when the percent is plainly zero).
// A finished result sits in the output register, so the next sample is taken while rsp_ch
// stalls; a second result then waits in the sequencer until the first beat is taken.
// Reset (synchronous) restores the register defaults, clears the filter and the burst count,
// and drops rsp_ch.valid.
`timescale 1ns / 1ps
`default_nettype none
module battery_charge_level_estimator_unit #(
   parameter int ADC_BITS = bcle_pkg::ADC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bcle_req_if.sink   req_ch,
   bcle_rsp_if.source rsp_ch,
   bcle_csr_if.sink   csr_ch
);
   import bcle_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CONV,
      S_CONV_MUL,
      S_CONV_DIV,
      S_FILT,
      S_FILT_MUL,
      S_CHECK,
      S_PCT,
      S_PCT_MUL,
      S_PCT_DIV,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [ADC_BITS-1:0] code_ff, code_in;
   logic [31:0]         x_ff, x_in;
   logic [31:0]         filt_ff, filt_in;
   logic [7:0]          idx_ff, idx_in;
   logic [6:0]          pct_ff, pct_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [6:0]          rsp_pct_ff, rsp_pct_in;
   logic [15:0]         rsp_level_ff, rsp_level_in;

   logic                mode_ff, mode_in;
   logic [23:0]         scale_ff, scale_in;
   logic [16:0]         alpha_ff, alpha_in;
   logic [15:0]         min_ff, min_in;
   logic [15:0]         max_ff, max_in;
   logic [7:0]          count_ff, count_in;

   mul_req_type         mul_req;
   mul_rsp_type         mul_rsp;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [16:0]         alpha_sat;
   logic signed [32:0]  diff;
   logic signed [32:0]  lvl_dev;
   logic signed [32:0]  lvl_dev_neg;
   logic signed [16:0]  span;
   logic signed [16:0]  span_neg;
   logic [31:0]         dev_mag;
   logic [15:0]         span_mag;
   logic                pct_zero;
   logic                accept;
   logic                rsp_free;

   bcle_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req_in  (mul_req),
      .rsp_out (mul_rsp)
   );

   bcle_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req_in  (div_req),
      .rsp_out (div_rsp)
   );

   assign accept   = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign alpha_sat   = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign diff        = $signed({1'b0, x_ff}) - $signed({1'b0, filt_ff});
   assign lvl_dev     = $signed({1'b0, filt_ff}) - $signed({1'b0, min_ff, 16'h0000});
   assign lvl_dev_neg = -lvl_dev;
   assign span        = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
   assign span_neg    = -span;
   assign dev_mag     = lvl_dev[32] ? lvl_dev_neg[31:0] : lvl_dev[31:0];
   assign span_mag    = span[16] ? span_neg[15:0] : span[15:0];
   // A quotient of opposite signs truncates to zero or below, which clamps to zero.
   assign pct_zero    = (span == '0) || (lvl_dev == '0) || (lvl_dev[32] != span[16]);

   always_comb begin
      mul_req.valid = 1'b0;
      mul_req.a     = MUL_A_W'($signed({1'b0, code_ff}));
      mul_req.b     = MUL_B_W'($signed({1'b0, scale_ff}));
      div_req.start    = 1'b0;
      div_req.dividend = DIV_N_W'(SUPPLY_NUM);
      div_req.divisor  = DIV_D_W'(code_ff);
      case (state_ff)
         S_CONV: begin
            if (!mode_ff) begin
               mul_req.valid = 1'b1;
            end else if (code_ff != '0) begin
               div_req.start = 1'b1;
            end
         end
         S_FILT: begin
            mul_req.valid = (idx_ff != '0);
            mul_req.a     = MUL_A_W'(diff);
            mul_req.b     = MUL_B_W'($signed({1'b0, alpha_sat}));
         end
         S_PCT: begin
            mul_req.valid = !pct_zero;
            mul_req.a     = MUL_A_W'($signed({1'b0, dev_mag}));
            mul_req.b     = MUL_B_W'($signed({1'b0, PCT_MAX}));
         end
         S_PCT_MUL: begin
            div_req.start    = mul_rsp.valid;
            div_req.dividend = mul_rsp.product[DIV_N_W-1:0];
            div_req.divisor  = {span_mag, 16'h0000};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      x_in         = x_ff;
      filt_in      = filt_ff;
      idx_in       = idx_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pct_in   = rsp_pct_ff;
      rsp_level_in = rsp_level_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               code_in  = ADC_BITS'(req_ch.adc_code);
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (!mode_ff) begin
               state_in = S_CONV_MUL;
            end else if (code_ff == '0) begin
               x_in     = {SAT_MV, 16'h0000};
               state_in = S_FILT;
            end else begin
               state_in = S_CONV_DIV;
            end
         end
         S_CONV_MUL: begin
            if (mul_rsp.valid) begin
               x_in     = (|mul_rsp.product[MUL_P_W-1:32]) ? 32'hFFFF_FFFF
                                                           : mul_rsp.product[31:0];
               state_in = S_FILT;
            end
         end
         S_CONV_DIV: begin
            if (div_rsp.done) begin
               x_in     = (|div_rsp.quotient[DIV_N_W-1:16]) ? {SAT_MV, 16'h0000}
                                                            : {div_rsp.quotient[15:0], 16'h0000};
               state_in = S_FILT;
            end
         end
         S_FILT: begin
            if (idx_ff == '0) begin
               filt_in  = x_ff;
               state_in = S_CHECK;
            end else begin
               state_in = S_FILT_MUL;
            end
         end
         S_FILT_MUL: begin
            // filt + floor(alpha * (x - filt) / 2^16); the true sum always fits 32 bits.
            if (mul_rsp.valid) begin
               filt_in  = filt_ff + mul_rsp.product[47:16];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (idx_ff >= count_ff) begin
               idx_in   = '0;
               state_in = S_PCT;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = S_IDLE;
            end
         end
         S_PCT: begin
            if (pct_zero) begin
               pct_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_PCT_MUL;
            end
         end
         S_PCT_MUL: begin
            if (mul_rsp.valid) begin
               state_in = S_PCT_DIV;
            end
         end
         S_PCT_DIV: begin
            if (div_rsp.done) begin
               pct_in   = (div_rsp.quotient > DIV_N_W'(PCT_MAX)) ? PCT_MAX
                                                                 : div_rsp.quotient[6:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = pct_ff;
               rsp_level_in = filt_ff[31:16];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      scale_in = scale_ff;
      alpha_in = alpha_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      count_in = count_ff;
      if (csr_ch.valid) begin
         case (reg_idx_type'(csr_ch.index))
            REG_SOURCE_MODE:  mode_in  = csr_ch.wdata[0];
            REG_SCALE_Q16:    scale_in = csr_ch.wdata[23:0];
            REG_ALPHA_Q16:    alpha_in = csr_ch.wdata[16:0];
            REG_MIN_MV:       min_in   = csr_ch.wdata[15:0];
            REG_MAX_MV:       max_in   = csr_ch.wdata[15:0];
            REG_SAMPLE_COUNT: count_in = csr_ch.wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filt_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= RST_SOURCE_MODE;
         scale_ff     <= RST_SCALE_Q16;
         alpha_ff     <= RST_ALPHA_Q16;
         min_ff       <= RST_MIN_MV;
         max_ff       <= RST_MAX_MV;
         count_ff     <= RST_SAMPLE_CNT;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         scale_ff     <= scale_in;
         alpha_ff     <= alpha_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
      end
      code_ff      <= code_in;
      x_ff         <= x_in;
      pct_ff       <= pct_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.percent  = rsp_pct_ff;
   assign rsp_ch.level_mv = rsp_level_ff;

endmodule
`default_nettype wire

FILE: sv/bcle_mul.sv
// Shared two-stage signed multiplier: registered operands, registered product.
`timescale 1ns / 1ps
`default_nettype none
module bcle_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  bcle_pkg::mul_req_type req_in,
   output bcle_pkg::mul_rsp_type rsp_out
);
   import bcle_pkg::*;

   logic signed [MUL_A_W-1:0] a_ff;
   logic signed [MUL_B_W-1:0] b_ff;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic                      stage1_ff;
   logic                      stage2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
      end else begin
         stage1_ff <= req_in.valid;
         stage2_ff <= stage1_ff;
      end
      if (req_in.valid) begin
         a_ff <= req_in.a;
         b_ff <= req_in.b;
      end
      prod_ff <= MUL_P_W'(a_ff * b_ff);
   end

   assign rsp_out.valid   = stage2_ff;
   assign rsp_out.product = prod_ff;

endmodule
`default_nettype wire

FILE: sv/bcle_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bcle_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bcle_pkg::div_req_type req_in,
   output bcle_pkg::div_rsp_type rsp_out
);
   import bcle_pkg::*;

   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W+1:0]   trial;

   // The dividend shifts out of the top of quo_ff while quotient bits enter below.
   assign shifted = {rem_ff, quo_ff[DIV_N_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req_in.start) begin
         quo_in  = req_in.dividend;
         rem_in  = '0;
         dsr_in  = req_in.divisor;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_D_W+1]) begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp_out.done     = done_ff;
   assign rsp_out.quotient = quo_ff;

endmodule
`default_nettype wire

FILE: sv/bcle_checker.sv
// Port-level checker for the battery charge level estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_charge_level_estimator_unit_defines.svh"
module bcle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_percent,
   input logic [15:0] rsp_level_mv
);
   import bcle_pkg::*;

   logic        rsp_stall;
   logic [22:0] rsp_beat;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_beat  = {rsp_percent, rsp_level_mv};

   `BCLE_ASSERT_IMP(a_pct_range, clock, reset, rsp_valid, rsp_percent <= PCT_MAX, "percent above 100")
   `BCLE_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready after beat")
   `BCLE_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `BCLE_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat), "beat changed")

endmodule

bind battery_charge_level_estimator_unit bcle_checker u_bcle_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_percent  (rsp_ch.percent),
   .rsp_level_mv (rsp_ch.level_mv)
);
`default_nettype wire
